// File: sv/pngu_pkg.sv
// shared constants, types and codes for the png unfilter / unpremultiply core
package pngu_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = 13;
  localparam int HGT_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEPS  = 16;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] FILT_MAX     = 8'd4;

  typedef enum logic [2:0] {
    FILT_NONE,
    FILT_SUB,
    FILT_UP,
    FILT_AVG,
    FILT_PAETH
  } filt_t;

  typedef struct packed {
    logic start;
    logic step;
  } lane_ctl_t;

endpackage

// File: sv/pngu_in_if.sv
// input item channel
interface pngu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] filter_type;
  logic [7:0] in_blue;
  logic [7:0] in_green;
  logic [7:0] in_red;
  logic [7:0] in_alpha;

  modport source (output valid, filter_type, in_blue, in_green, in_red, in_alpha,
                  input ready);
  modport sink   (input valid, filter_type, in_blue, in_green, in_red, in_alpha,
                  output ready);
endinterface

// File: sv/pngu_out_if.sv
// result item channel
interface pngu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       row_end;
  logic       image_end;
  logic       bad_filter;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, row_end,
                  image_end, bad_filter, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, row_end,
                  image_end, bad_filter, output ready);
endinterface

// File: sv/pngu_cfg_if.sv
// configuration write channel
interface pngu_cfg_if;
  import pngu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/pngu_lane.sv
// one byte lane: filter predictor and bit-serial unpremultiply divider
module pngu_lane
  import pngu_pkg::*;
(
  input  logic        clk,
  input  lane_ctl_t   ctl,
  input  filt_t       filt,
  input  logic [7:0]  raw,
  input  logic [7:0]  left,
  input  logic [7:0]  up,
  input  logic [7:0]  ul,
  output logic [7:0]  recon,
  input  logic [7:0]  div_c,
  input  logic [7:0]  div_a,
  output logic [15:0] quot
);

  logic [8:0]        sum_ab;
  logic signed [9:0] pa, pb, pc;
  logic [7:0]        paeth;
  logic [7:0]        pred;
  logic [15:0]       num_r;
  logic [7:0]        rem_r;
  logic [7:0]        den_r;
  logic [8:0]        trial;

  assign sum_ab = {1'b0, left} + {1'b0, up};

  always_comb begin
    pa = $signed({2'b00, up}) - $signed({2'b00, ul});
    pb = $signed({2'b00, left}) - $signed({2'b00, ul});
    pc = pa + pb;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) paeth = left;
    else if (pb <= pc)        paeth = up;
    else                      paeth = ul;
  end

  always_comb begin
    unique case (filt)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase
  end

  assign recon = raw + pred;

  // restoring division, quotient shifts into the dividend register
  assign trial = {rem_r, num_r[15]};

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      num_r <= {div_c, 8'd0} - {8'd0, div_c} + {9'd0, div_a[7:1]};
      rem_r <= 8'd0;
      den_r <= div_a;
    end else if (ctl.step) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= 8'(trial - {1'b0, den_r});
        num_r <= {num_r[14:0], 1'b1};
      end else begin
        rem_r <= trial[7:0];
        num_r <= {num_r[14:0], 1'b0};
      end
    end
  end

  assign quot = num_r;

endmodule

// File: sv/png_unfilter_unpremultiply_core.sv
// top level: png filter reconstruction of bgra pixels with unpremultiply
//
//  channel  dir  handshake    payload
//  in_ch    in   valid/ready  filter_type, in_blue, in_green, in_red, in_alpha
//  out_ch   out  valid/ready  out_red/green/blue/alpha, row_end, image_end, bad_filter
//  cfg_ch   in   valid/ready  index (0 width_pixels, 1 height_rows), data
//
// one item at a time, and a new item is taken only after the last one's output load:
// accept, line store read and reconstruction, the bit-serial divider in the four lanes, then the output load
// reset is synchronous active low; the line store needs no clearing, row zero reads zero
// a stalled output holds its item and the next item waits before the output load
// cfg writes are always taken
module png_unfilter_unpremultiply_core
  import pngu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pngu_in_if.sink    in_ch,
  pngu_out_if.source out_ch,
  pngu_cfg_if.sink   cfg_ch
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_DONE} state_t;

  state_t             state_r;
  logic [WID_W-1:0]   width_r;
  logic [HGT_W-1:0]   height_r;
  logic [COL_W-1:0]   col_r;
  logic [HGT_W-1:0]   row_r;
  filt_t              filt_r;
  logic               err_r;
  logic [31:0]        left_r, ul_r, px_r, raw_r, mem_q;
  logic [7:0]         ftype_r;
  logic [DCNT_W-1:0]  cnt_r;
  logic               row_end_r, img_end_r, bad_r;
  logic               out_valid_r;
  logic [7:0]         o_red_r, o_green_r, o_blue_r, o_alpha_r;
  logic               o_row_r, o_img_r, o_bad_r;
  logic [31:0]        mem [MAX_WIDTH];

  logic               in_acc, first, ftype_bad, err_now, row_end, img_end;
  logic               out_load;
  filt_t              filt_cur;
  logic [31:0]        left, up, ul, px_nxt;
  logic [WID_W-1:0]   width_eff;
  logic [HGT_W-1:0]   height_eff;
  lane_ctl_t          ctl;
  logic [15:0]        quot [4];
  logic [7:0]         col_out [3];
  logic               bypass;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign first     = (col_r == '0);
  assign ftype_bad = (ftype_r > FILT_MAX);
  assign err_now   = err_r | (first & ftype_bad);

  always_comb begin
    if (!first)         filt_cur = filt_r;
    else if (ftype_bad) filt_cur = FILT_NONE;
    else                filt_cur = filt_t'(ftype_r[2:0]);
  end

  assign left = first ? 32'd0 : left_r;
  assign up   = (row_r == '0) ? 32'd0 : mem_q;
  assign ul   = (first || row_r == '0) ? 32'd0 : ul_r;

  always_comb begin
    if (width_r == '0)                          width_eff = WID_W'(1);
    else if (width_r > WID_W'(MAX_WIDTH))       width_eff = WID_W'(MAX_WIDTH);
    else                                        width_eff = width_r;
  end
  assign height_eff = (height_r == '0) ? HGT_W'(1) : height_r;

  assign row_end = ({1'b0, col_r} + (COL_W + 1)'(1)) >= (COL_W + 1)'(width_eff);
  assign img_end = row_end && (({1'b0, row_r} + 17'd1) >= {1'b0, height_eff});

  assign ctl.start = (state_r == S_READ);
  assign ctl.step  = (state_r == S_DIV);

  for (genvar k = 0; k < 4; k++) begin : g_lane
    pngu_lane u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .filt  (filt_cur),
      .raw   (raw_r[8*k +: 8]),
      .left  (left[8*k +: 8]),
      .up    (up[8*k +: 8]),
      .ul    (ul[8*k +: 8]),
      .recon (px_nxt[8*k +: 8]),
      .div_c (px_nxt[8*k +: 8]),
      .div_a (px_nxt[31:24]),
      .quot  (quot[k])
    );
  end

  // merge: pick lane quotient, saturate, or pass colour through
  assign bypass = (px_r[31:24] == ALPHA_CLEAR) || (px_r[31:24] == ALPHA_OPAQUE);
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (bypass)                 col_out[k] = px_r[8*k +: 8];
      else if (|quot[k][15:8])    col_out[k] = 8'hFF;
      else                        col_out[k] = quot[k][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) mem_q <= mem[col_r];
    if (state_r == S_READ) mem[col_r] <= px_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= WID_W'(1);
      height_r    <= HGT_W'(1);
      col_r       <= '0;
      row_r       <= '0;
      filt_r      <= FILT_NONE;
      err_r       <= 1'b0;
      left_r      <= '0;
      ul_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_WIDTH:  width_r  <= cfg_ch.data[WID_W-1:0];
          REG_HEIGHT: height_r <= cfg_ch.data[HGT_W-1:0];
          default: ;
        endcase
      end
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            raw_r   <= {in_ch.in_alpha, in_ch.in_red, in_ch.in_green, in_ch.in_blue};
            ftype_r <= in_ch.filter_type;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          px_r      <= px_nxt;
          left_r    <= px_nxt;
          ul_r      <= up;
          filt_r    <= filt_cur;
          row_end_r <= row_end;
          img_end_r <= img_end;
          bad_r     <= err_now;
          err_r     <= img_end ? 1'b0 : err_now;
          if (row_end) begin
            col_r <= '0;
            row_r <= img_end ? '0 : row_r + HGT_W'(1);
          end else begin
            col_r <= col_r + COL_W'(1);
          end
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + DCNT_W'(1);
          if (cnt_r == DCNT_W'(DIV_STEPS - 1)) state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            o_red_r     <= col_out[2];
            o_green_r   <= col_out[1];
            o_blue_r    <= col_out[0];
            o_alpha_r   <= px_r[31:24];
            o_row_r     <= row_end_r;
            o_img_r     <= img_end_r;
            o_bad_r     <= bad_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_red    = o_red_r;
  assign out_ch.out_green  = o_green_r;
  assign out_ch.out_blue   = o_blue_r;
  assign out_ch.out_alpha  = o_alpha_r;
  assign out_ch.row_end    = o_row_r;
  assign out_ch.image_end  = o_img_r;
  assign out_ch.bad_filter = o_bad_r;

  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_READ)
    else $error("accepted item did not enter read");

  a_read_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> state_r == S_DIV && cnt_r == '0)
    else $error("divider did not start after read");

  a_img_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_img_r |-> o_row_r)
    else $error("image end without row end");

  a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ && img_end |=> !err_r)
    else $error("error flag survived image end");

endmodule

// File: tb/pngu_tb_pkg.sv
// testbench types: one input pixel and one expected output pixel
package pngu_tb_pkg;

  typedef struct packed {
    logic [7:0] filter_type;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       image_end;
    logic       bad_filter;
  } pix_out_t;

endpackage

// File: tb/pngu_checker.sv
// checker: reconstructs expected pixels from accepted inputs and compares outputs
module pngu_checker
  import pngu_pkg::*;
  import pngu_tb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pngu_in_if   in_mon,
  pngu_out_if  out_mon,
  pngu_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending
);

  logic [31:0] row_pixels [MAX_WIDTH];
  logic [31:0] left_px;
  logic [31:0] upleft_px;
  int unsigned col_pos;
  int unsigned row_pos;
  logic [7:0]  row_filter;
  logic        filter_error;
  int unsigned cfg_width;
  int unsigned cfg_height;
  pix_out_t    expected_pixels [$];

  function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int p, pa, pb, pc;
    p = int'(a) + int'(b) - int'(c);
    pa = p - int'(a);
    pb = p - int'(b);
    pc = p - int'(c);
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  function automatic logic [7:0] unpremultiply(logic [7:0] c, logic [7:0] a);
    int unsigned v;
    if (a == ALPHA_CLEAR || a == ALPHA_OPAQUE) return c;
    v = (int'(c) * 255 + int'(a) / 2) / int'(a);
    return v > 255 ? 8'd255 : v[7:0];
  endfunction

  task automatic reconstruct(pix_in_t pin);
    int unsigned w, h;
    logic [31:0] raw, left, up, ul, px;
    logic [7:0] a, b, c, pred;
    logic first;
    pix_out_t po;
    w = cfg_width == 0 ? 1 : (cfg_width > MAX_WIDTH ? MAX_WIDTH : cfg_width);
    h = cfg_height == 0 ? 1 : cfg_height;
    first = (col_pos == 0);
    if (first) begin
      row_filter = pin.filter_type;
      if (row_filter > FILT_MAX) filter_error = 1'b1;
    end
    raw = {pin.alpha, pin.red, pin.green, pin.blue};
    left = first ? '0 : left_px;
    ul = (first || row_pos == 0) ? '0 : upleft_px;
    up = (row_pos != 0 && col_pos < MAX_WIDTH) ? row_pixels[col_pos] : '0;
    for (int k = 0; k < 4; k++) begin
      a = left[8*k +: 8];
      b = up[8*k +: 8];
      c = ul[8*k +: 8];
      case (row_filter)
        8'(FILT_SUB):   pred = a;
        8'(FILT_UP):    pred = b;
        8'(FILT_AVG):   pred = 8'((9'(a) + 9'(b)) >> 1);
        8'(FILT_PAETH): pred = paeth_pick(a, b, c);
        default:        pred = 8'd0;
      endcase
      px[8*k +: 8] = raw[8*k +: 8] + pred;
    end
    if (col_pos < MAX_WIDTH) row_pixels[col_pos] = px;
    left_px = px;
    upleft_px = up;
    po.alpha = px[31:24];
    po.red = unpremultiply(px[23:16], px[31:24]);
    po.green = unpremultiply(px[15:8], px[31:24]);
    po.blue = unpremultiply(px[7:0], px[31:24]);
    po.row_end = (col_pos + 1 >= w);
    po.image_end = po.row_end && (row_pos + 1 >= h);
    po.bad_filter = filter_error;
    expected_pixels = {expected_pixels, po};
    if (po.row_end) begin
      col_pos = 0;
      if (po.image_end) begin
        row_pos = 0;
        filter_error = 1'b0;
      end else begin
        row_pos = (row_pos + 1) & 16'hFFFF;
      end
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  always @(posedge clk) begin
    pix_out_t got, want;
    if (!rst_n) begin
      left_px = '0;
      upleft_px = '0;
      col_pos = 0;
      row_pos = 0;
      row_filter = '0;
      filter_error = 1'b0;
      cfg_width = 1;
      cfg_height = 1;
      fail_count = 0;
      expected_pixels.delete();
      pending = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_WIDTH) cfg_width = cfg_mon.data & 16'h1FFF;
        else if (cfg_mon.index == REG_HEIGHT) cfg_height = cfg_mon.data;
      end
      if (in_mon.valid && in_mon.ready)
        reconstruct({in_mon.filter_type, in_mon.in_blue, in_mon.in_green,
                     in_mon.in_red, in_mon.in_alpha});
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.out_red, out_mon.out_green, out_mon.out_blue, out_mon.out_alpha,
               out_mon.row_end, out_mon.image_end, out_mon.bad_filter};
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected output item %p", got);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      pending = expected_pixels.size();
    end
  end

endmodule

// File: tb/tb.sv
// testbench top: stimulus, idling phases and verdict for the png unfilter core
module tb;
  import pngu_pkg::*;
  import pngu_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_cycles;

  pngu_in_if  in_ch();
  pngu_out_if out_ch();
  pngu_cfg_if cfg_ch();

  png_unfilter_unpremultiply_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  pngu_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_pixel(pix_in_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.filter_type, in_ch.in_blue, in_ch.in_green, in_ch.in_red, in_ch.in_alpha} <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic pix_in_t rand_pixel(bit row_start);
    pix_in_t p;
    p = $urandom;
    if (row_start) p.filter_type = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(4));
    else if ($urandom_range(1)) p.filter_type = 8'($urandom);
    case ($urandom_range(5))
      0: p.alpha = ALPHA_CLEAR;
      1: p.alpha = ALPHA_OPAQUE;
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_image(int w, int h);
    write_reg(REG_WIDTH, 16'(w));
    write_reg(REG_HEIGHT, 16'(h));
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) send_pixel(rand_pixel(c == 0));
    drain();
  endtask

  initial begin
    pix_in_t p;
    int sent;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_ch.valid = 1'b0;
    {in_ch.filter_type, in_ch.in_blue, in_ch.in_green, in_ch.in_red, in_ch.in_alpha} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_WIDTH;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: filters none, sub, up and a bad filter over a 3x4 image, extremes of bytes and alpha
    write_reg(REG_WIDTH, 16'd3);
    write_reg(REG_HEIGHT, 16'd4);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 3; c++) begin
        p.filter_type = (r == 3) ? 8'd255 : 8'(r + c);
        p.blue = c[0] ? 8'hFF : 8'h00;
        p.green = 8'h80 + 8'(r);
        p.red = 8'hFF;
        p.alpha = (c == 0) ? ALPHA_CLEAR : (c == 1 ? ALPHA_OPAQUE : 8'd1);
        send_pixel(p);
      end
    drain();
    write_reg(REG_WIDTH, 16'd1);
    write_reg(REG_HEIGHT, 16'd4);
    for (int i = 0; i < 4; i++) begin
      p = {8'(FILT_PAETH) + 8'(i), 8'd200, 8'd100, 8'd50, 8'd128};
      send_pixel(p);
    end
    drain();
    // out-of-range sizes act as 1 and as the maximum width
    write_reg(REG_WIDTH, 16'd0);
    write_reg(REG_HEIGHT, 16'd0);
    send_pixel('1);
    send_pixel('0);
    drain();
    write_reg(REG_WIDTH, 16'h1FFF);
    write_reg(REG_HEIGHT, 16'hFFFF);
    send_pixel(rand_pixel(1'b1));
    drain();
    // write reset the position counters via a full image end
    send_image(1, 1);

    // random phases
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1 ? 56 : 0);
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1 ? 11 : 0);
      sent = 0;
      while (sent < 140) begin
        int w, h;
        w = $urandom_range(1, 9);
        h = $urandom_range(1, 5);
        if (phase == 2 && sent == 0) hold_cycles = 300;
        send_image(w, h);
        sent += w * h;
      end
    end
    send_image(2, 65535 / 65535 * 3);

    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #30000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
sv/pngu_pkg.sv
sv/pngu_in_if.sv
sv/pngu_out_if.sv
sv/pngu_cfg_if.sv
sv/pngu_lane.sv
sv/png_unfilter_unpremultiply_core.sv
tb/pngu_tb_pkg.sv
tb/pngu_checker.sv
tb/tb.sv
